FILE: rtl/pbmdec_pkg.sv
// Shared constants and helpers for the PBM/PGM binary stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package pbmdec_pkg;

  // Default largest accepted width or height
  localparam int MAX_DIM_DEF = 4096;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int OUT_DATA_W = 64;   // 61 payload bits padded to whole bytes

  // Header number accumulator saturates at 65536
  localparam int               NUM_W   = 17;
  localparam logic [NUM_W-1:0] NUM_SAT = 17'h10000;

  localparam logic [BYTE_W-1:0] MAXVAL_MAX   = 8'd255;
  localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd100;
  localparam logic [BYTE_W-1:0] PIX_BLACK    = 8'h00;
  localparam logic [BYTE_W-1:0] PIX_WHITE    = 8'hFF;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // Characters
  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_4    = 8'h34;
  localparam logic [BYTE_W-1:0] CH_5    = 8'h35;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT   = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_CR) || (b == CH_VT) || (b == CH_FF);
  endfunction

  function automatic logic is_eol(input logic [BYTE_W-1:0] b);
    return (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pbm_pgm_binary_decoder.sv
// Streaming decoder for binary PBM (P4) and PGM (P5) image files.
`timescale 1ns / 1ps
`default_nettype none

// Takes an image file one byte per word on the in_ stream and parses the
// netpbm header ("P4" or "P5", width, height and for P5 maxval, with '#'
// comments), giving one header word when the header is done and then one
// pixel word per pixel with column, row and a dark flag (value below the
// dark threshold register). A P4 byte unpacks MSB first, set bit = black (0),
// clear bit = white (255), and each P4 row starts on a new byte. A bad magic,
// a stray character, a zero or oversize dimension or a maxval of 0 or above
// 255 gives one error word, after which the block stays quiet until a byte
// with start_of_file. A new header byte or P5 data byte can enter each cycle
// while out_tready holds; a P4 data byte stays held until it has given its
// pixel words, up to eight or to the end of the row, because the single output
// register moves one result word per cycle unless out_tready stalls it. The
// byte holding register and the output register are separate, so the next
// byte is taken while a finished word waits for out_tready; the parse step is
// one pass of logic between them. The dark threshold register resets to 100;
// the user must write it only while the block is idle; the block does not enforce this.
module pbm_pgm_binary_decoder #(
  parameter int MAX_DIM = pbmdec_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration: dark_threshold
  input  wire logic                              cfg_wr_en,
  input  wire logic [pbmdec_pkg::BYTE_W-1:0]     cfg_wr_data,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pbmdec_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] byte_in
  input  wire logic [0:0]                        in_tuser,   // [0] start_of_file
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] pixel_value, [8] pixel_dark, [20:9] col, [32:21] row,
  // [33] end_of_image, [46:34] image_width, [59:47] image_height,
  // [60] is_gray, [63:61] zero
  output logic [pbmdec_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [pbmdec_pkg::KIND_W-1:0]          out_tuser,  // [1:0] result_kind
  output logic                                   out_tlast   // last_in_byte
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = pbmdec_pkg::NUM_W + 4;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_D,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // Byte holding register
  logic                             hold_valid_r;
  logic [pbmdec_pkg::BYTE_W-1:0]    hold_byte_r;
  logic                             hold_sof_r;
  logic [2:0]                       bit_idx_r;

  // Parser state
  phase_t                           phase_r, phase_cur, phase_nxt;
  logic                             comment_r, comment_cur, comment_nxt;
  logic [pbmdec_pkg::NUM_W-1:0]     accum_r, accum_cur, accum_nxt;
  logic                             digits_r, digits_cur, digits_nxt;
  logic [DIM_W-1:0]                 width_r, width_cur, width_nxt;
  logic [DIM_W-1:0]                 height_r, height_cur, height_nxt;
  logic                             gray_r, gray_cur, gray_nxt;
  logic [DIM_W-1:0]                 col_r, col_cur, col_nxt;
  logic [DIM_W-1:0]                 row_r, row_cur, row_nxt;
  logic [pbmdec_pkg::BYTE_W-1:0]    thresh_r;

  // Output register
  logic                             out_valid_r;
  logic [pbmdec_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [pbmdec_pkg::KIND_W-1:0]    out_kind_r;
  logic                             out_last_r;

  // Step results
  logic                             adv;
  logic                             done;
  logic                             emit;
  logic                             finish;
  logic                             fail;
  logic [pbmdec_pkg::KIND_W-1:0]    kind;
  logic [pbmdec_pkg::BYTE_W-1:0]    pix_val;
  logic                             pix_dark;
  logic [DIM_W-1:0]                 col_o, row_o;
  logic                             last_o, eoi_o;
  logic [pbmdec_pkg::BYTE_W-1:0]    b;
  logic [pbmdec_pkg::BYTE_W-1:0]    dig;
  logic [ACC_W-1:0]                 acc_calc;
  logic [DIM_W:0]                   col_inc, row_inc;
  logic                             wrap;
  logic                             num_ok_dim;
  logic                             num_ok_max;
  logic [31:0]                      col_w, row_w, width_w, height_w;

  assign b   = hold_byte_r;
  assign dig = b - pbmdec_pkg::CH_0;

  // Step through the held byte whenever the output register is free
  assign adv       = hold_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !hold_valid_r || (adv && done);

  assign num_ok_dim = (accum_cur != '0) && (32'(accum_cur) <= 32'(MAX_DIM));
  assign num_ok_max = (accum_cur != '0) &&
                      (accum_cur <= pbmdec_pkg::NUM_W'(pbmdec_pkg::MAXVAL_MAX));

  always_comb begin
    // start_of_file restarts the parser before the byte is used
    phase_cur   = hold_sof_r ? PH_MAGIC_P : phase_r;
    comment_cur = hold_sof_r ? 1'b0 : comment_r;
    accum_cur   = hold_sof_r ? '0 : accum_r;
    digits_cur  = hold_sof_r ? 1'b0 : digits_r;
    width_cur   = hold_sof_r ? '0 : width_r;
    height_cur  = hold_sof_r ? '0 : height_r;
    gray_cur    = hold_sof_r ? 1'b0 : gray_r;
    col_cur     = hold_sof_r ? '0 : col_r;
    row_cur     = hold_sof_r ? '0 : row_r;

    phase_nxt   = phase_cur;
    comment_nxt = comment_cur;
    accum_nxt   = accum_cur;
    digits_nxt  = digits_cur;
    width_nxt   = width_cur;
    height_nxt  = height_cur;
    gray_nxt    = gray_cur;
    col_nxt     = col_cur;
    row_nxt     = row_cur;

    done     = 1'b1;
    emit     = 1'b0;
    finish   = 1'b0;
    fail     = 1'b0;
    kind     = pbmdec_pkg::KIND_PIXEL;
    pix_val  = '0;
    col_o    = '0;
    row_o    = '0;
    last_o   = 1'b1;
    eoi_o    = 1'b0;
    wrap     = 1'b0;
    col_inc  = '0;
    row_inc  = '0;
    acc_calc = ({4'b0, accum_cur} << 3) + ({4'b0, accum_cur} << 1) +
               ACC_W'(dig[3:0]);

    case (phase_cur)
      PH_MAGIC_P: begin
        if (b == pbmdec_pkg::CH_P) begin
          phase_nxt = PH_MAGIC_D;
        end else begin
          fail = 1'b1;
        end
      end
      PH_MAGIC_D: begin
        if (b == pbmdec_pkg::CH_4) begin
          gray_nxt  = 1'b0;
          phase_nxt = PH_WIDTH;
        end else if (b == pbmdec_pkg::CH_5) begin
          gray_nxt  = 1'b1;
          phase_nxt = PH_WIDTH;
        end else begin
          fail = 1'b1;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (!(comment_cur && !pbmdec_pkg::is_eol(b))) begin
          comment_nxt = 1'b0;
          if (b >= pbmdec_pkg::CH_0 && b <= pbmdec_pkg::CH_9) begin
            if (acc_calc > ACC_W'(pbmdec_pkg::NUM_SAT)) begin
              accum_nxt = pbmdec_pkg::NUM_SAT;
            end else begin
              accum_nxt = acc_calc[pbmdec_pkg::NUM_W-1:0];
            end
            digits_nxt = 1'b1;
          end else if (b == pbmdec_pkg::CH_HASH) begin
            comment_nxt = 1'b1;
          end else if (pbmdec_pkg::is_ws(b)) begin
            finish = digits_cur;
          end else begin
            fail = 1'b1;
          end
        end
      end
      PH_DATA: begin
        emit  = 1'b1;
        col_o = col_cur;
        row_o = row_cur;
        if (gray_cur) begin
          pix_val = b;
        end else begin
          pix_val = b[3'd7 - bit_idx_r] ? pbmdec_pkg::PIX_BLACK : pbmdec_pkg::PIX_WHITE;
        end
        col_inc = {1'b0, col_cur} + 1'b1;
        wrap    = col_inc >= {1'b0, width_cur};
        if (wrap) begin
          col_nxt = '0;
          row_inc = {1'b0, row_cur} + 1'b1;
          row_nxt = row_inc[DIM_W-1:0];
          if (row_inc >= {1'b0, height_cur}) begin
            eoi_o     = 1'b1;
            phase_nxt = PH_DONE;
          end
        end else begin
          col_nxt = col_inc[DIM_W-1:0];
        end
        // a P4 byte ends at its eighth bit or at the end of the row
        last_o = gray_cur || (bit_idx_r == 3'd7) || wrap;
        done   = last_o;
      end
      default: ;
    endcase

    // a header number just ended
    if (finish) begin
      accum_nxt  = '0;
      digits_nxt = 1'b0;
      case (phase_cur)
        PH_WIDTH: begin
          if (num_ok_dim) begin
            width_nxt = DIM_W'(accum_cur);
            phase_nxt = PH_HEIGHT;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HEIGHT: begin
          if (!num_ok_dim) begin
            fail = 1'b1;
          end else if (gray_cur) begin
            height_nxt = DIM_W'(accum_cur);
            phase_nxt  = PH_MAXVAL;
          end else begin
            height_nxt = DIM_W'(accum_cur);
            phase_nxt  = PH_DATA;
            col_nxt    = '0;
            row_nxt    = '0;
            emit       = 1'b1;
            kind       = pbmdec_pkg::KIND_HEADER;
          end
        end
        default: begin
          if (num_ok_max) begin
            phase_nxt = PH_DATA;
            col_nxt   = '0;
            row_nxt   = '0;
            emit      = 1'b1;
            kind      = pbmdec_pkg::KIND_HEADER;
          end else begin
            fail = 1'b1;
          end
        end
      endcase
    end

    if (fail) begin
      phase_nxt   = PH_ERROR;
      comment_nxt = 1'b0;
      emit        = 1'b1;
      kind        = pbmdec_pkg::KIND_ERROR;
    end
  end

  assign pix_dark = (phase_cur == PH_DATA) && (pix_val < thresh_r);

  // Size the position and dimension fields to the port widths
  assign col_w    = 32'(col_o);
  assign row_w    = 32'(row_o);
  assign width_w  = 32'(width_nxt);
  assign height_w = 32'(height_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      hold_sof_r   <= 1'b0;
      bit_idx_r    <= '0;
      phase_r      <= PH_MAGIC_P;
      comment_r    <= 1'b0;
      accum_r      <= '0;
      digits_r     <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
      gray_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      thresh_r     <= pbmdec_pkg::THRESH_RESET;
      out_valid_r  <= 1'b0;
      out_kind_r   <= pbmdec_pkg::KIND_PIXEL;
      out_last_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end

      if (in_tvalid && in_tready) begin
        hold_valid_r <= 1'b1;
        hold_byte_r  <= in_tdata;
        hold_sof_r   <= in_tuser[0];
      end else if (adv && done) begin
        hold_valid_r <= 1'b0;
      end

      if (adv) begin
        bit_idx_r   <= done ? 3'd0 : bit_idx_r + 3'd1;
        phase_r     <= phase_nxt;
        comment_r   <= comment_nxt;
        accum_r     <= accum_nxt;
        digits_r    <= digits_nxt;
        width_r     <= width_nxt;
        height_r    <= height_nxt;
        gray_r      <= gray_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= emit;
        out_kind_r  <= kind;
        out_last_r  <= last_o;
        out_data_r  <= {3'b0, gray_nxt, height_w[12:0], width_w[12:0], eoi_o,
                        row_w[11:0], col_w[11:0], pix_dark, pix_val};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Header and error words always close their byte
  a_nonpixel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != pbmdec_pkg::KIND_PIXEL) |-> out_last_r)
    else $error("header or error word without last_in_byte");

  // End of image only on a pixel word that also closes its byte
  a_eoi_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[33] |-> out_last_r &&
    (out_kind_r == pbmdec_pkg::KIND_PIXEL))
    else $error("end_of_image on a non-final or non-pixel word");

  // Only P4 data bytes step through bits
  a_bit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r != 3'd0 |-> hold_valid_r && (phase_r == PH_DATA) && !gray_r &&
    !hold_sof_r)
    else $error("bit index advanced outside P4 data");

  // Data phase always has nonzero dimensions and an in-range position
  a_data_dims: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (width_r != '0) && (height_r != '0) &&
    (col_r < width_r) && (row_r < height_r))
    else $error("data phase with invalid size or position");

  // Result kind code 3 is never produced
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == pbmdec_pkg::KIND_PIXEL) ||
    (out_kind_r == pbmdec_pkg::KIND_HEADER) || (out_kind_r == pbmdec_pkg::KIND_ERROR))
    else $error("undefined result kind");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the PBM/PGM binary stream decoder.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIM        = pbmdec_pkg::MAX_DIM_DEF;
  localparam int SETTLE_CYCLES  = 24;    // lets the tail of a multi-pixel P4 byte drain
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either side
  localparam int WORDS_PER_PHASE = 45;

  // Parser phases of the predictor
  typedef enum logic [3:0] {
    ST_MAGIC, ST_DIGIT, ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_PIXELS, ST_DONE, ST_ERROR
  } dec_phase_t;

  // One expected result word
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        dark;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic        eoi;
    logic [12:0] width;
    logic [12:0] height;
    logic        gray;
  } dec_word_t;

  // One file byte waiting to be sent
  typedef struct {
    logic [7:0] b;
    logic       sof;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_wr_en   = 1'b0;
  logic [pbmdec_pkg::BYTE_W-1:0]     cfg_wr_data = '0;
  logic                              in_tvalid   = 1'b0;
  logic                              in_tready;
  logic [pbmdec_pkg::BYTE_W-1:0]     in_tdata    = '0;
  logic [0:0]                        in_tuser    = '0;
  logic                              out_tvalid;
  logic                              out_tready  = 1'b0;
  logic [pbmdec_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [pbmdec_pkg::KIND_W-1:0]     out_tuser;
  logic                              out_tlast;

  pbm_pgm_binary_decoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and the threshold register
  // ---------------------------------------------------------------------------
  dec_phase_t phase;
  logic       in_cmt;
  int         num;
  logic       have_digits;
  int         img_w, img_h;
  logic       gray;
  int         col_n, row_n;
  logic [7:0] thresh = pbmdec_pkg::THRESH_RESET;

  dec_word_t  expected_words[$];
  file_byte_t file_bytes[$];

  int  bytes_queued = 0;  // bytes handed to the sender so far
  int  bytes_taken  = 0;  // bytes the block has accepted
  int  words_seen   = 0;
  int  mismatches   = 0;
  int  idle_cycles  = 0;
  int  in_gap       = 0;
  int  out_stall    = 0;
  bit  in_taken     = 1'b0;
  bit  no_idling    = 1'b0;  // final phase runs both sides flat out

  function automatic void clear_parser();
    phase       = ST_MAGIC;
    in_cmt      = 1'b0;
    num         = 0;
    have_digits = 1'b0;
    img_w       = 0;
    img_h       = 0;
    gray        = 1'b0;
    col_n       = 0;
    row_n       = 0;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == pbmdec_pkg::CH_SP || b == pbmdec_pkg::CH_TAB || b == pbmdec_pkg::CH_LF ||
           b == pbmdec_pkg::CH_CR || b == pbmdec_pkg::CH_VT || b == pbmdec_pkg::CH_FF;
  endfunction

  function automatic void expect_word(logic [1:0] kind, logic [7:0] value, logic dark,
                                      int c, int r, logic last, logic eoi);
    dec_word_t w;
    w.kind   = kind;
    w.value  = value;
    w.dark   = dark;
    w.col    = c[11:0];
    w.row    = r[11:0];
    w.last   = last;
    w.eoi    = eoi;
    w.width  = img_w[12:0];
    w.height = img_h[12:0];
    w.gray   = gray;
    expected_words.push_back(w);
  endfunction

  // One error word, then silence until the next start of file
  function automatic void flag_error();
    phase  = ST_ERROR;
    in_cmt = 1'b0;
    expect_word(pbmdec_pkg::KIND_ERROR, 8'd0, 1'b0, 0, 0, 1'b1, 1'b0);
  endfunction

  // Whitespace after digits closes the current header field
  function automatic void end_number();
    int   v;
    logic hdr;
    v           = num;
    hdr         = 1'b0;
    num         = 0;
    have_digits = 1'b0;
    if (phase == ST_WIDTH) begin
      if (v == 0 || v > MAX_DIM) flag_error();
      else begin
        img_w = v;
        phase = ST_HEIGHT;
      end
    end else if (phase == ST_HEIGHT) begin
      if (v == 0 || v > MAX_DIM) flag_error();
      else begin
        img_h = v;
        if (gray) phase = ST_MAXVAL;
        else hdr = 1'b1;
      end
    end else if (v == 0 || v > 255) begin
      flag_error();
    end else begin
      hdr = 1'b1;
    end
    if (hdr) begin
      phase = ST_PIXELS;
      col_n = 0;
      row_n = 0;
      expect_word(pbmdec_pkg::KIND_HEADER, 8'd0, 1'b0, 0, 0, 1'b1, 1'b0);
    end
  endfunction

  // Emits one pixel word and advances the raster; returns 1 on the last pixel
  function automatic logic put_pixel(logic [7:0] v, logic last_of_byte);
    int   c, r;
    logic eoi;
    c   = col_n;
    r   = row_n;
    eoi = 1'b0;
    col_n++;
    if (col_n >= img_w) begin
      col_n = 0;
      row_n++;
      if (row_n >= img_h) begin
        eoi   = 1'b1;
        phase = ST_DONE;
      end
    end
    expect_word(pbmdec_pkg::KIND_PIXEL, v, v < thresh, c, r, last_of_byte || eoi, eoi);
    return eoi;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof);
    int left, n;
    if (sof) clear_parser();
    case (phase)
      ST_MAGIC: begin
        if (b != pbmdec_pkg::CH_P) flag_error();
        else phase = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (b == pbmdec_pkg::CH_4) begin
          gray  = 1'b0;
          phase = ST_WIDTH;
        end else if (b == pbmdec_pkg::CH_5) begin
          gray  = 1'b1;
          phase = ST_WIDTH;
        end else begin
          flag_error();
        end
      end
      ST_WIDTH, ST_HEIGHT, ST_MAXVAL: begin
        // inside a comment only LF or CR matter, and they then act as whitespace
        if (!in_cmt || b == pbmdec_pkg::CH_LF || b == pbmdec_pkg::CH_CR) begin
          in_cmt = 1'b0;
          if (b >= pbmdec_pkg::CH_0 && b <= pbmdec_pkg::CH_9) begin
            num = num * 10 + int'(b - pbmdec_pkg::CH_0);
            if (num > int'(pbmdec_pkg::NUM_SAT)) num = int'(pbmdec_pkg::NUM_SAT);
            have_digits = 1'b1;
          end else if (b == pbmdec_pkg::CH_HASH) begin
            in_cmt = 1'b1;
          end else if (is_blank(b)) begin
            if (have_digits) end_number();
          end else begin
            flag_error();
          end
        end
      end
      ST_PIXELS: begin
        if (gray) begin
          void'(put_pixel(b, 1'b1));
        end else begin
          // P4: MSB first, only up to the end of the current row
          left = img_w - col_n;
          n    = (left < 8) ? left : 8;
          for (int k = 0; k < n; k++) begin
            if (put_pixel(b[7-k] ? pbmdec_pkg::PIX_BLACK : pbmdec_pkg::PIX_WHITE,
                          k + 1 == n)) break;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                words_seen, name, got, want));
  endtask

  task automatic check_word();
    dec_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected (kind %0d)",
                                words_seen, out_tuser));
    end else begin
      w = expected_words.pop_front();
      compare_field("result_kind",  16'(out_tuser),        16'(w.kind));
      compare_field("pixel_value",  16'(out_tdata[7:0]),   16'(w.value));
      compare_field("pixel_dark",   16'(out_tdata[8]),     16'(w.dark));
      compare_field("col",          16'(out_tdata[20:9]),  16'(w.col));
      compare_field("row",          16'(out_tdata[32:21]), 16'(w.row));
      compare_field("end_of_image", 16'(out_tdata[33]),    16'(w.eoi));
      compare_field("image_width",  16'(out_tdata[46:34]), 16'(w.width));
      compare_field("image_height", 16'(out_tdata[59:47]), 16'(w.height));
      compare_field("is_gray",      16'(out_tdata[60]),    16'(w.gray));
      compare_field("padding",      16'(out_tdata[63:61]), 16'd0);
      compare_field("last_in_byte", 16'(out_tlast),        16'(w.last));
    end
    words_seen++;
  endtask

  // Monitor: sample both handshakes at the rising edge. The byte is predicted
  // before the result is checked, so a same-cycle result would still line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser[0]);
        bytes_taken++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) check_word();
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        report_mismatch($sformatf("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT));
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and receiver, both at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      file_byte_t fb;
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (file_bytes.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 15);  // start a burst of idle cycles
        in_tvalid <= 1'b0;
      end else begin
        fb = file_bytes.pop_front();
        in_tdata  <= fb.b;
        in_tuser  <= fb.sof;
        in_tvalid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b, logic sof);
    file_byte_t fb;
    fb.b   = b;
    fb.sof = sof;
    file_bytes.push_back(fb);
    bytes_queued++;
  endtask

  // sof goes on the first character only
  task automatic push_text(string s, logic sof);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], sof && i == 0);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return pbmdec_pkg::CH_SP;
      1: return pbmdec_pkg::CH_TAB;
      2: return pbmdec_pkg::CH_LF;
      3: return pbmdec_pkg::CH_CR;
      4: return pbmdec_pkg::CH_VT;
      default: return pbmdec_pkg::CH_FF;
    endcase
  endfunction

  function automatic string num_text(int v);
    if ($urandom_range(0, 7) == 0) return {"0", $sformatf("%0d", v)};
    return $sformatf("%0d", v);
  endfunction

  // Field separator: whitespace or a comment ended by LF/CR. The separator
  // that ends the header must be a single one, or extra blanks become data.
  task automatic push_sep(logic single);
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      push_byte(pbmdec_pkg::CH_HASH, 1'b0);
      repeat ($urandom_range(0, 3)) begin
        do c = 8'($urandom_range(0, 255));
        while (c == pbmdec_pkg::CH_LF || c == pbmdec_pkg::CH_CR);
        push_byte(c, 1'b0);
      end
      push_byte($urandom_range(0, 1) ? pbmdec_pkg::CH_LF : pbmdec_pkg::CH_CR, 1'b0);
    end else begin
      push_byte(blank_char(), 1'b0);
    end
    if (!single) repeat ($urandom_range(0, 1)) push_byte(blank_char(), 1'b0);
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return thresh - 8'd1;
      3: return thresh;
      4: return pbmdec_pkg::CH_HASH;  // plain data once past the header
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A well-formed file with random layout; some are cut short, some have
  // bytes trailing after the last pixel.
  task automatic push_image();
    logic g;
    int   w, h, nbytes;
    g = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: w = MAX_DIM;
        1: w = MAX_DIM - 1;
        default: w = $urandom_range(9, MAX_DIM);
      endcase
      h = ($urandom_range(0, 1) != 0) ? MAX_DIM : $urandom_range(1, MAX_DIM);
    end else begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 3);
    end
    push_text("P", 1'b1);
    push_byte(g ? pbmdec_pkg::CH_5 : pbmdec_pkg::CH_4, 1'b0);
    if ($urandom_range(0, 3) != 0) push_sep(1'b0);  // else width follows the magic
    push_text(num_text(w), 1'b0);
    push_sep(1'b0);
    push_text(num_text(h), 1'b0);
    if (g) begin
      push_sep(1'b0);
      push_text(num_text(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255)), 1'b0);
    end
    push_sep(1'b1);
    nbytes = g ? w * h : ((w + 7) / 8) * h;
    if (nbytes > 40) nbytes = $urandom_range(0, 6);
    else if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes - 1);
    repeat (nbytes) push_byte(data_byte(), 1'b0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // A broken file with one randomly chosen kind of format error, then a few ignored bytes
  task automatic push_bad();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: begin
        do c = 8'($urandom_range(0, 255)); while (c == pbmdec_pkg::CH_P);
        push_byte(c, 1'b1);
      end
      1: begin
        push_text("P", 1'b1);
        do c = 8'($urandom_range(0, 255));
        while (c == pbmdec_pkg::CH_4 || c == pbmdec_pkg::CH_5);
        push_byte(c, 1'b0);
      end
      2: begin
        push_text($urandom_range(0, 1) ? "P4 " : "P5 ", 1'b1);
        push_text(num_text($urandom_range(1, 99)), 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == pbmdec_pkg::CH_HASH ||
               (c >= pbmdec_pkg::CH_0 && c <= pbmdec_pkg::CH_9));
        push_byte(c, 1'b0);
      end
      3: push_text("P4 0 ", 1'b1);
      4: begin
        if ($urandom_range(0, 1) != 0) push_text("P5 4097 ", 1'b1);
        else push_text("P4 123456789\n", 1'b1);  // accumulator saturates
      end
      5: begin
        if ($urandom_range(0, 1) != 0) push_text("P5 3 0 ", 1'b1);
        else push_text("P4 3 5000\t", 1'b1);
      end
      6: push_text("P5 2 2 0\n", 1'b1);
      default: begin
        if ($urandom_range(0, 1) != 0) push_text("P5 2 2 256 ", 1'b1);
        else push_text("P5 1 1 99999 ", 1'b1);
      end
    endcase
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Block is idle: every byte taken, every result in, and the tail of a
  // multi-pixel P4 byte given time to drain.
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    thresh      = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] levels[4];
    int         phase_start;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, with the reset threshold:
    // P4 with width right after the magic, one set bit, then a byte after the image
    @(posedge clk);
    push_text("P41 1\n", 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(pbmdec_pkg::CH_HASH, 1'b0);
    // P5 with every odd whitespace kind and the top maxval, one white pixel
    push_text("P5", 1'b1);
    push_byte(pbmdec_pkg::CH_FF, 1'b0);
    push_text("1", 1'b0);
    push_byte(pbmdec_pkg::CH_TAB, 1'b0);
    push_text("1", 1'b0);
    push_byte(pbmdec_pkg::CH_CR, 1'b0);
    push_text("255", 1'b0);
    push_byte(pbmdec_pkg::CH_VT, 1'b0);
    push_byte(8'hFF, 1'b0);
    // bad magic, then a stray character after the magic
    push_byte(8'h51, 1'b1);
    push_text("P4x", 1'b1);
    wait_idle();

    // Random phases, each at a new threshold; the sender holds off between
    // phases until every result is in. Last phase runs without idling.
    levels[0] = 8'd0;
    levels[1] = 8'd255;
    levels[2] = 8'($urandom_range(1, 254));
    levels[3] = 8'd128;
    for (int p = 0; p < 4; p++) begin
      write_threshold(levels[p]);
      @(posedge clk);
      no_idling   = (p == 3);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 3) == 0) push_bad();
        else push_image();
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pbmdec_pkg.sv
rtl/pbm_pgm_binary_decoder.sv
tb/tb.sv
